/* design/token_ring_link_controller_assert.svh */
// Assertion macros for the token ring link controller.
`ifndef TOKEN_RING_LINK_CONTROLLER_ASSERT_SVH
`define TOKEN_RING_LINK_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLC_ASSERT(lbl, prop, msg)
`define TLC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* design/tlc_pkg.sv */
package tlc_pkg;

  localparam int MBOX_DEPTH = 16;
  localparam int MBOX_AW    = $clog2(MBOX_DEPTH);
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [1:0] OP_LINE_BYTE = 2'd0;
  localparam logic [1:0] OP_TIMEOUT   = 2'd1;
  localparam logic [1:0] OP_SEND      = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_LINE    = 2'd1;
  localparam logic [1:0] KIND_MAILBOX = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic CFG_STATION_ID    = 1'b0;
  localparam logic CFG_STATION_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] line_byte;
    logic [1:0] send_dest;
    logic [7:0] send_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [1:0] message_sender;
    logic [3:0] message_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] station_id;
    logic [2:0] station_count;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LINE = 2'd0,
    CMD_SEND = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               mb_wr;
    logic [MBOX_AW-1:0] mb_idx;
    logic [7:0]         byte_val;
    logic               end_frame;
    logic               rx_match;
    logic [1:0]         sender;
    logic [3:0]         length;
    logic               xmit;
    logic [1:0]         dest;
  } cmd_t;

endpackage

/* design/tlc_front.sv */
module tlc_front import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic       in_payload_r, in_payload_nxt;
  logic [1:0] frame_sender_r, frame_sender_nxt;
  logic [1:0] frame_receiver_r, frame_receiver_nxt;
  logic [3:0] frame_length_r, frame_length_nxt;
  logic [3:0] payload_index_r, payload_index_nxt;
  logic [3:0] idx_inc;

  function automatic logic token_match(input logic [1:0] snd, input logic [2:0] cnt,
                                       input logic [1:0] id);
    logic [2:0] v;
    logic [2:0] r;
    logic       ok;
    v  = {1'b0, snd} + 3'd1;
    r  = 3'd0;
    ok = 1'b1;
    case (cnt)
      3'd0: ok = 1'b0;
      3'd1: r = 3'd0;
      3'd2: r = {2'b00, v[0]};
      3'd3: r = (v >= 3'd3) ? v - 3'd3 : v;
      default: r = (v >= cnt) ? v - cnt : v;
    endcase
    return ok && (r == {1'b0, id});
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign idx_inc  = payload_index_r + 4'd1;

  always_comb begin
    in_payload_nxt     = in_payload_r;
    frame_sender_nxt   = frame_sender_r;
    frame_receiver_nxt = frame_receiver_r;
    frame_length_nxt   = frame_length_r;
    payload_index_nxt  = payload_index_r;
    q_cmd              = '0;
    q_cmd.kind         = CMD_LINE;
    unique case (in_data.operation)
      OP_LINE_BYTE: begin
        if (!in_payload_r) begin
          frame_sender_nxt   = in_data.line_byte[7:6];
          frame_receiver_nxt = in_data.line_byte[5:4];
          frame_length_nxt   = in_data.line_byte[3:0];
          payload_index_nxt  = 4'd0;
          if (in_data.line_byte[3:0] != 4'd0) begin
            in_payload_nxt = 1'b1;
          end else begin
            q_cmd.xmit = token_match(in_data.line_byte[7:6], cfg.station_count,
                                     cfg.station_id);
          end
        end else begin
          q_cmd.mb_wr       = (frame_receiver_r == cfg.station_id);
          q_cmd.mb_idx      = payload_index_r[MBOX_AW-1:0];
          q_cmd.byte_val    = in_data.line_byte;
          payload_index_nxt = idx_inc;
          if (idx_inc >= frame_length_r) begin
            q_cmd.end_frame = 1'b1;
            q_cmd.rx_match  = (frame_receiver_r == cfg.station_id);
            q_cmd.sender    = frame_sender_r;
            q_cmd.length    = frame_length_r;
            q_cmd.xmit      = token_match(frame_sender_r, cfg.station_count,
                                          cfg.station_id);
            in_payload_nxt  = 1'b0;
          end
        end
      end
      OP_TIMEOUT: begin
        if (in_payload_r) begin
          q_cmd.end_frame = 1'b1;
          q_cmd.rx_match  = (frame_receiver_r == cfg.station_id);
          q_cmd.sender    = frame_sender_r;
          q_cmd.length    = frame_length_r;
          q_cmd.xmit      = token_match(frame_sender_r, cfg.station_count,
                                        cfg.station_id);
          in_payload_nxt  = 1'b0;
        end else begin
          q_cmd.xmit = 1'b1;
        end
      end
      OP_SEND: begin
        q_cmd.kind     = CMD_SEND;
        q_cmd.dest     = in_data.send_dest;
        q_cmd.byte_val = in_data.send_data;
      end
      OP_READ: begin
        q_cmd.kind = CMD_READ;
      end
      default: begin
        q_cmd.kind = CMD_LINE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r     <= 1'b0;
      frame_sender_r   <= 2'd0;
      frame_receiver_r <= 2'd0;
      frame_length_r   <= 4'd0;
      payload_index_r  <= 4'd0;
    end else if (q_push) begin
      in_payload_r     <= in_payload_nxt;
      frame_sender_r   <= frame_sender_nxt;
      frame_receiver_r <= frame_receiver_nxt;
      frame_length_r   <= frame_length_nxt;
      payload_index_r  <= payload_index_nxt;
    end
  end

endmodule

/* design/tlc_cmd_fifo.sv */
module tlc_cmd_fifo import tlc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   count_r;

  assign full  = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/tlc_back.sv */
module tlc_back import tlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_TX_DATA  = 4'b0010,
    S_RD_FETCH = 4'b0100,
    S_RD_EMIT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               tx_pending_r, tx_pending_nxt;
  logic [1:0]         tx_dest_r, tx_dest_nxt;
  logic [7:0]         tx_data_r, tx_data_nxt;
  logic [3:0]         mb_len_r, mb_len_nxt;
  logic [1:0]         mb_sender_r, mb_sender_nxt;
  logic [MBOX_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]         rd_data_r;
  logic [7:0]         mbox_mem [MBOX_DEPTH];
  logic               mb_we;
  logic               slot_free;
  logic               rd_last;

  function automatic out_item_t mk_out(input logic [1:0] kind, input logic [1:0] st,
                                       input logic [7:0] data, input logic [1:0] snd,
                                       input logic [3:0] len, input logic lst);
    out_item_t o;
    o.result_kind    = kind;
    o.status         = st;
    o.data_byte      = data;
    o.message_sender = snd;
    o.message_length = len;
    o.last           = lst;
    return o;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_last   = ({{(4-MBOX_AW){1'b0}}, rd_idx_r} == (mb_len_r - 4'd1));

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    tx_pending_nxt = tx_pending_r;
    tx_dest_nxt    = tx_dest_r;
    tx_data_nxt    = tx_data_r;
    mb_len_nxt     = mb_len_r;
    mb_sender_nxt  = mb_sender_r;
    rd_idx_nxt     = rd_idx_r;
    cmd_pop        = 1'b0;
    mb_we          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(KIND_ACK, ST_OK, 8'd0, 2'd0, 4'd0, 1'b1);
          unique case (cmd.kind)
            CMD_LINE: begin
              mb_we = cmd.mb_wr;
              if (cmd.end_frame) begin
                if (cmd.rx_match) begin
                  mb_sender_nxt = cmd.sender;
                  mb_len_nxt    = cmd.length;
                end else begin
                  mb_len_nxt = 4'd0;
                end
              end
              if (cmd.xmit) begin
                if (tx_pending_r) begin
                  out_nxt = mk_out(KIND_LINE, ST_OK, {cfg.station_id, tx_dest_r, 4'b0001},
                                   2'd0, 4'd0, 1'b0);
                  tx_pending_nxt = 1'b0;
                  state_nxt      = S_TX_DATA;
                end else begin
                  out_nxt = mk_out(KIND_LINE, ST_OK, {cfg.station_id, 6'd0},
                                   2'd0, 4'd0, 1'b1);
                end
              end
            end
            CMD_SEND: begin
              if (tx_pending_r) begin
                out_nxt = mk_out(KIND_ACK, ST_BUSY, 8'd0, 2'd0, 4'd0, 1'b1);
              end else begin
                tx_pending_nxt = 1'b1;
                tx_dest_nxt    = cmd.dest;
                tx_data_nxt    = cmd.byte_val;
              end
            end
            CMD_READ: begin
              if (mb_len_r == 4'd0) begin
                out_nxt = mk_out(KIND_ACK, ST_EMPTY, 8'd0, 2'd0, 4'd0, 1'b1);
              end else begin
                out_valid_nxt = 1'b0;
                rd_idx_nxt    = '0;
                state_nxt     = S_RD_FETCH;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_TX_DATA: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(KIND_LINE, ST_OK, tx_data_r, 2'd0, 4'd0, 1'b1);
          state_nxt     = S_IDLE;
        end
      end
      S_RD_FETCH: begin
        state_nxt = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = mk_out(KIND_MAILBOX, ST_OK, rd_data_r, mb_sender_r, mb_len_r, rd_last);
          if (rd_last) begin
            mb_len_nxt = 4'd0;
            state_nxt  = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            state_nxt  = S_RD_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mb_we) begin
      mbox_mem[cmd.mb_idx] <= cmd.byte_val;
    end
    if (state_r == S_RD_FETCH) begin
      rd_data_r <= mbox_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      tx_pending_r <= 1'b0;
      tx_dest_r    <= 2'd0;
      tx_data_r    <= 8'd0;
      mb_len_r     <= 4'd0;
      mb_sender_r  <= 2'd0;
      rd_idx_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      tx_pending_r <= tx_pending_nxt;
      tx_dest_r    <= tx_dest_nxt;
      tx_data_r    <= tx_data_nxt;
      mb_len_r     <= mb_len_nxt;
      mb_sender_r  <= mb_sender_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

endmodule

/* design/token_ring_link_controller.sv */
// Path: a single result passes the command queue and the output register; the first byte of a
// mailbox read also passes S_RD_FETCH, the registered mailbox read port and S_RD_EMIT.
// Flow: one input per cycle into a two-entry command queue while it is not full; the executor
// retires a single-result command per cycle while the output is not stalled, a transmit with
// data through S_TX_DATA, and a mailbox read through S_RD_FETCH and S_RD_EMIT for each byte.
// Reset: rst_n synchronous active low clears control, queue and config (id 0, count 1).
`include "token_ring_link_controller_assert.svh"

module token_ring_link_controller import tlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [2:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cfg_t cfg_r;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_empty;
  logic out_ack, out_mbox, out_line;

  assign out_ack  = out_valid && (out_data.result_kind == KIND_ACK);
  assign out_mbox = out_valid && (out_data.result_kind == KIND_MAILBOX);
  assign out_line = out_valid && (out_data.result_kind == KIND_LINE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_id    <= 2'd0;
      cfg_r.station_count <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATION_ID:    cfg_r.station_id    <= cfg_wdata[1:0];
        CFG_STATION_COUNT: cfg_r.station_count <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  tlc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  tlc_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  tlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TLC_ASSERT(a_mbox_len, out_mbox |-> out_data.message_length != 4'd0, "empty mailbox byte")
  `TLC_ASSERT(a_ack_clean, out_ack |-> out_data.last && out_data.data_byte == 8'd0, "bad ack")
  `TLC_ASSERT(a_line_ok, out_line |-> out_data.status == ST_OK, "line byte not ok")
  `TLC_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !q_pop, "activity right after reset")

endmodule

/* bench/token_ring_link_checker.sv */
`timescale 1ns / 100ps

module token_ring_link_checker import tlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [1:0] my_id;
  logic [2:0] ring_size;
  logic       in_frame;
  logic [1:0] frm_sender;
  logic [1:0] frm_receiver;
  logic [3:0] frm_length;
  logic [3:0] rx_index;
  logic [7:0] mbox [MBOX_DEPTH];
  logic [3:0] mbox_len;
  logic [1:0] mbox_sender;
  logic       tx_queued;
  logic [1:0] tx_dest_q;
  logic [7:0] tx_byte_q;

  out_item_t burst[$];
  out_item_t due_results[$];

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (fail_count < 30)
      $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic out_item_t make_result(input logic [1:0] kind, input logic [1:0] st,
                                            input logic [7:0] data, input logic [1:0] snd,
                                            input logic [3:0] len);
    out_item_t r;
    r.result_kind    = kind;
    r.status         = st;
    r.data_byte      = data;
    r.message_sender = snd;
    r.message_length = len;
    r.last           = 1'b0;
    return r;
  endfunction

  task automatic send_on_line();
    if (tx_queued) begin
      burst.push_back(make_result(KIND_LINE, ST_OK, {my_id, tx_dest_q, 4'h1}, 2'd0, 4'd0));
      burst.push_back(make_result(KIND_LINE, ST_OK, tx_byte_q, 2'd0, 4'd0));
      tx_queued = 1'b0;
    end else begin
      burst.push_back(make_result(KIND_LINE, ST_OK, {my_id, 6'd0}, 2'd0, 4'd0));
    end
  endtask

  task automatic pass_token_if_due();
    if (ring_size != 3'd0 && ((int'(frm_sender) + 1) % int'(ring_size)) == int'(my_id))
      send_on_line();
  endtask

  task automatic close_frame();
    if (frm_receiver == my_id) begin
      mbox_sender = frm_sender;
      mbox_len    = frm_length;
    end else begin
      mbox_len = 4'd0;
    end
    in_frame = 1'b0;
  endtask

  task automatic station_response(input in_item_t item);
    burst.delete();
    case (item.operation)
      OP_LINE_BYTE: begin
        if (!in_frame) begin
          frm_sender   = item.line_byte[7:6];
          frm_receiver = item.line_byte[5:4];
          frm_length   = item.line_byte[3:0];
          rx_index     = 4'd0;
          if (frm_length != 4'd0) in_frame = 1'b1;
          else pass_token_if_due();
        end else begin
          if (frm_receiver == my_id) mbox[rx_index] = item.line_byte;
          rx_index = rx_index + 4'd1;
          if (rx_index >= frm_length) begin
            close_frame();
            pass_token_if_due();
          end
        end
      end
      OP_TIMEOUT: begin
        if (in_frame) begin
          close_frame();
          pass_token_if_due();
        end else begin
          send_on_line();
        end
      end
      OP_SEND: begin
        if (tx_queued) begin
          burst.push_back(make_result(KIND_ACK, ST_BUSY, 8'd0, 2'd0, 4'd0));
        end else begin
          tx_dest_q = item.send_dest;
          tx_byte_q = item.send_data;
          tx_queued = 1'b1;
          burst.push_back(make_result(KIND_ACK, ST_OK, 8'd0, 2'd0, 4'd0));
        end
      end
      OP_READ: begin
        if (mbox_len == 4'd0) begin
          burst.push_back(make_result(KIND_ACK, ST_EMPTY, 8'd0, 2'd0, 4'd0));
        end else begin
          for (int i = 0; i < mbox_len; i++)
            burst.push_back(make_result(KIND_MAILBOX, ST_OK, mbox[i], mbox_sender, mbox_len));
          mbox_len = 4'd0;
        end
      end
    endcase
    if (burst.size() == 0)
      burst.push_back(make_result(KIND_ACK, ST_OK, 8'd0, 2'd0, 4'd0));
    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) due_results.push_back(burst[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report("unexpected transfer, data_byte", got.data_byte, 8'd0);
    end else begin
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", 8'(got.result_kind), 8'(want.result_kind));
      if (got.status !== want.status)
        report("status", 8'(got.status), 8'(want.status));
      if (got.data_byte !== want.data_byte)
        report("data_byte", got.data_byte, want.data_byte);
      if (got.message_sender !== want.message_sender)
        report("message_sender", 8'(got.message_sender), 8'(want.message_sender));
      if (got.message_length !== want.message_length)
        report("message_length", 8'(got.message_length), 8'(want.message_length));
      if (got.last !== want.last)
        report("last", 8'(got.last), 8'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      my_id       = 2'd0;
      ring_size   = 3'd1;
      in_frame    = 1'b0;
      frm_sender  = 2'd0;
      frm_receiver = 2'd0;
      frm_length  = 4'd0;
      rx_index    = 4'd0;
      mbox_len    = 4'd0;
      mbox_sender = 2'd0;
      tx_queued   = 1'b0;
      tx_dest_q   = 2'd0;
      tx_byte_q   = 8'd0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STATION_ID) my_id = cfg_wdata[1:0];
        else ring_size = cfg_wdata;
      end
      if (in_valid && in_ready) station_response(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    pending = due_results.size();
  end

endmodule

/* bench/tb_token_ring_link_controller.sv */
`timescale 1ns / 100ps

module tb_token_ring_link_controller;
  import tlc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  int unsigned fails;
  int unsigned pending;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  logic [1:0]  cur_id = 2'd0;

  int unsigned phase_gap   [6] = '{0, 59, 0, 24, 24, 0};
  int unsigned phase_stall [6] = '{0, 0, 59, 24, 0, 59};
  logic [1:0]  phase_id    [6] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2};
  logic [2:0]  phase_count [6] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd3};

  token_ring_link_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  token_ring_link_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fails), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #1000000;
    $display("tb_token_ring_link_controller: errors");
    $finish;
  end

  task automatic issue(input logic [1:0] op, input logic [7:0] lb, input logic [1:0] dst,
                       input logic [7:0] dat);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, lb, dst, dat};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold off until every transfer owed by the block has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ring(input logic [1:0] id, input logic [2:0] count);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STATION_ID;
    cfg_wdata <= {1'($urandom), id};
    @(posedge clk);
    cfg_index <= CFG_STATION_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_id = id;
  endtask

  task automatic ring_traffic(input int unsigned target);
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [1:0]  rcv;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(7) == 0) ? 15 : $urandom_range(5);
        rcv = ($urandom_range(1) == 1) ? cur_id : 2'($urandom);
        cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
        issue(OP_LINE_BYTE, {2'($urandom), rcv, 4'(len)}, 2'($urandom), 8'($urandom));
        for (int i = 0; i < len && i <= cut; i++)
          issue((i == cut) ? OP_TIMEOUT : OP_LINE_BYTE, 8'($urandom), 2'($urandom),
                8'($urandom));
      end else if (pick < 60) begin
        issue(OP_SEND, 8'($urandom), 2'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        issue(OP_READ, 8'($urandom), 2'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        issue(OP_TIMEOUT, 8'($urandom), 2'($urandom), 8'($urandom));
      end else begin
        issue(2'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_READ, 8'h00, 2'd0, 8'h00);
    // full frame to this station: fills every mailbox entry that a read can reach
    issue(OP_LINE_BYTE, 8'hCF, 2'd0, 8'h00);
    for (int i = 0; i < 15; i++)
      issue(OP_LINE_BYTE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
            2'($urandom), 8'($urandom));
    issue(OP_SEND, 8'hFF, 2'd3, 8'hFF);
    issue(OP_SEND, 8'h00, 2'd0, 8'h00);
    issue(OP_TIMEOUT, 8'h00, 2'd0, 8'h00);
    issue(OP_TIMEOUT, 8'hFF, 2'd3, 8'hFF);
    issue(OP_READ, 8'hFF, 2'd3, 8'hFF);
    issue(OP_READ, 8'h00, 2'd0, 8'h00);
    issue(OP_LINE_BYTE, 8'h00, 2'd0, 8'h00);
    issue(OP_LINE_BYTE, 8'h12, 2'd0, 8'h00);
    issue(OP_TIMEOUT, 8'h00, 2'd0, 8'h00);
    issue(OP_READ, 8'h00, 2'd0, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      set_ring(phase_id[ph], phase_count[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      ring_traffic(items_sent + 23);
    end

    settle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fails == 0 && pending == 0)
      $display("tb_token_ring_link_controller: clean");
    else
      $display("tb_token_ring_link_controller: errors");
    $finish;
  end

endmodule
